FILE: design/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, queue entry and result types shared by the engine modules.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int unsigned QueueDepth = 2;

  // Encoding of the kind field on the tick channel.
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_TX    = 3'd2;
  localparam logic [2:0] KIND_RX    = 3'd3;
  localparam logic [2:0] KIND_ACK   = 3'd4;
  localparam logic [2:0] KIND_NACK  = 3'd5;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'hFF;

  // Command after classification; CMD_NONE covers no offer and unknown kinds.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_TX,
    CMD_RX,
    CMD_ACK,
    CMD_NACK
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } result_t;

endpackage

FILE: design/i2cmbe_if.sv
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Valid/ready interfaces for the tick input and the line result output.
// ----------------------------------------------------------------------------
interface i2cmbe_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output cmd_valid, output kind, output tx_byte,
                  output sda_in, input ready);
  modport sink (input valid, input cmd_valid, input kind, input tx_byte,
                input sda_in, output ready);
endinterface

interface i2cmbe_result_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_released;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source (output valid, output scl_level, output sda_level,
                  output sda_released, output busy_res, output done_res,
                  output rx_byte, output ack_missing, input ready);
  modport sink (input valid, input scl_level, input sda_level,
                input sda_released, input busy_res, input done_res,
                input rx_byte, input ack_missing, output ready);
endinterface

FILE: design/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// I2C master byte engine front end
// Decodes each tick beat into a command code and queues it for the sequencer.
// ----------------------------------------------------------------------------
module i2cmbe_front (
  input  logic                clk,
  input  logic                rst,
  i2cmbe_tick_if.sink         tick,
  output i2cmbe_pkg::tick_t   head,
  output logic                head_valid,
  input  logic                pop
);
  import i2cmbe_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tick_t           queue [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  tick_t           entry;
  logic            push;
  logic            do_pop;

  always_comb begin
    entry.tx_byte = tick.tx_byte;
    entry.sda_in  = tick.sda_in;
    entry.cmd     = CMD_NONE;
    if (tick.cmd_valid) begin
      unique case (tick.kind)
        KIND_START: entry.cmd = CMD_START;
        KIND_STOP:  entry.cmd = CMD_STOP;
        KIND_TX:    entry.cmd = CMD_TX;
        KIND_RX:    entry.cmd = CMD_RX;
        KIND_ACK:   entry.cmd = CMD_ACK;
        KIND_NACK:  entry.cmd = CMD_NACK;
        default:    entry.cmd = CMD_NONE;
      endcase
    end
  end

  assign tick.ready = (count != CntW'(QueueDepth));
  assign push       = tick.valid && tick.ready;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/i2cmbe_back.sv
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer
// Steps the SCL/SDA sequence one tick per queued beat into an output register.
// ----------------------------------------------------------------------------
module i2cmbe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [7:0]         cfg_wdata,
  input  i2cmbe_pkg::tick_t  head,
  input  logic               head_valid,
  output logic               pop,
  i2cmbe_result_if.source    res
);
  import i2cmbe_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_STOP,
    PH_ACKB,
    PH_TXBIT,
    PH_TXLOW,
    PH_TXREL,
    PH_TXPOLL,
    PH_TXEND,
    PH_RX
  } phase_t;

  phase_t     phase, phase_next, phase_w;
  logic [2:0] bit_count, bit_count_next;
  logic [1:0] sub_step, sub_step_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] poll_count, poll_count_next;
  logic [7:0] rx_reg, rx_reg_next;
  logic       ack_error, ack_error_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic [7:0] ack_timeout;
  logic       busy, done, rel;
  logic       out_valid;
  result_t    out_data;

  assign pop = head_valid && (!out_valid || res.ready);

  always_comb begin
    phase_w         = phase;
    bit_count_next  = bit_count;
    sub_step_next   = sub_step;
    shift_reg_next  = shift_reg;
    poll_count_next = poll_count;
    rx_reg_next     = rx_reg;
    ack_error_next  = ack_error;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    busy            = 1'b0;
    done            = 1'b0;
    rel             = 1'b0;

    // A command is taken only on an idle tick and runs its first step at once.
    if (phase == PH_IDLE && head.cmd != CMD_NONE) begin
      sub_step_next  = '0;
      bit_count_next = '0;
      unique case (head.cmd)
        CMD_START: phase_w = PH_START;
        CMD_STOP:  phase_w = PH_STOP;
        CMD_TX: begin
          phase_w        = PH_TXBIT;
          shift_reg_next = head.tx_byte;
        end
        CMD_RX: begin
          phase_w        = PH_RX;
          shift_reg_next = '0;
          sda_reg_next   = 1'b1;
        end
        CMD_ACK: begin
          phase_w      = PH_ACKB;
          sda_reg_next = 1'b0;
        end
        default: begin
          phase_w      = PH_ACKB;
          sda_reg_next = 1'b1;
        end
      endcase
    end

    phase_next = phase_w;
    if (phase_w != PH_IDLE) begin
      busy = 1'b1;
      unique case (phase_w)
        PH_START: begin
          if (sub_step_next == 2'd0) begin
            scl_reg_next  = 1'b1;
            sda_reg_next  = 1'b1;
            sub_step_next = 2'd1;
          end else if (sub_step_next == 2'd1) begin
            sda_reg_next  = 1'b0;
            sub_step_next = 2'd2;
          end else begin
            scl_reg_next = 1'b0;
            done         = 1'b1;
          end
        end
        PH_STOP: begin
          if (sub_step_next == 2'd0) begin
            scl_reg_next  = 1'b0;
            sda_reg_next  = 1'b0;
            sub_step_next = 2'd1;
          end else if (sub_step_next == 2'd1) begin
            scl_reg_next  = 1'b1;
            sub_step_next = 2'd2;
          end else begin
            sda_reg_next = 1'b1;
            done         = 1'b1;
          end
        end
        PH_ACKB: begin
          if (sub_step_next == 2'd0) begin
            scl_reg_next  = 1'b1;
            sub_step_next = 2'd1;
          end else begin
            scl_reg_next = 1'b0;
            done         = 1'b1;
          end
        end
        PH_TXBIT: begin
          if (sub_step_next == 2'd0) begin
            scl_reg_next  = 1'b0;
            sda_reg_next  = shift_reg_next[7];
            sub_step_next = 2'd1;
          end else begin
            scl_reg_next   = 1'b1;
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
            sub_step_next  = 2'd0;
            if (bit_count_next == 3'd7) begin
              phase_next = PH_TXLOW;
            end else begin
              bit_count_next = bit_count_next + 1'b1;
            end
          end
        end
        PH_TXLOW: begin
          scl_reg_next = 1'b0;
          phase_next   = PH_TXREL;
        end
        PH_TXREL: begin
          rel             = 1'b1;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b1;
          // A timeout of zero still gives one poll.
          poll_count_next = (ack_timeout == '0) ? 8'd1 : ack_timeout;
          phase_next      = PH_TXPOLL;
        end
        PH_TXPOLL: begin
          rel             = 1'b1;
          scl_reg_next    = 1'b1;
          poll_count_next = poll_count - 1'b1;
          if (!head.sda_in) begin
            ack_error_next = 1'b0;
            phase_next     = PH_TXEND;
          end else if (poll_count_next == '0) begin
            ack_error_next = 1'b1;
            phase_next     = PH_TXEND;
          end
        end
        PH_TXEND: begin
          rel          = 1'b1;
          scl_reg_next = 1'b0;
          done         = 1'b1;
        end
        PH_RX: begin
          rel          = 1'b1;
          sda_reg_next = 1'b1;
          if (sub_step_next == 2'd0) begin
            scl_reg_next  = 1'b1;
            sub_step_next = 2'd1;
          end else if (sub_step_next == 2'd1) begin
            scl_reg_next   = 1'b1;
            shift_reg_next = {shift_reg_next[6:0], head.sda_in};
            sub_step_next  = 2'd2;
          end else begin
            scl_reg_next  = 1'b0;
            sub_step_next = 2'd0;
            if (bit_count_next == 3'd7) begin
              rx_reg_next = shift_reg_next;
              done        = 1'b1;
            end else begin
              bit_count_next = bit_count_next + 1'b1;
            end
          end
        end
        default: begin
          busy = 1'b0;
        end
      endcase
      if (done || !busy) begin
        phase_next     = PH_IDLE;
        sub_step_next  = '0;
        bit_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      sub_step    <= '0;
      shift_reg   <= '0;
      poll_count  <= '0;
      rx_reg      <= '0;
      ack_error   <= 1'b0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_timeout <= ACK_TIMEOUT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        ack_timeout <= cfg_wdata;
      end
      if (pop) begin
        phase                 <= phase_next;
        bit_count             <= bit_count_next;
        sub_step              <= sub_step_next;
        shift_reg             <= shift_reg_next;
        poll_count            <= poll_count_next;
        rx_reg                <= rx_reg_next;
        ack_error             <= ack_error_next;
        scl_reg               <= scl_reg_next;
        sda_reg               <= sda_reg_next;
        out_valid             <= 1'b1;
        out_data.scl_level    <= scl_reg_next;
        out_data.sda_level    <= sda_reg_next;
        out_data.sda_released <= rel;
        out_data.busy_res     <= busy;
        out_data.done_res     <= done;
        out_data.rx_byte      <= rx_reg_next;
        out_data.ack_missing  <= ack_error_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.scl_level    = out_data.scl_level;
  assign res.sda_level    = out_data.sda_level;
  assign res.sda_released = out_data.sda_released;
  assign res.busy_res     = out_data.busy_res;
  assign res.done_res     = out_data.done_res;
  assign res.rx_byte      = out_data.rx_byte;
  assign res.ack_missing  = out_data.ack_missing;

endmodule

FILE: design/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Each tick beat carries the sampled SDA level and an optional command
// (start, stop, send byte, receive byte, send ACK, send NACK). Each accepted
// tick beat yields exactly one result beat: the SCL and SDA levels for that
// tick, the SDA release flag, busy, a done pulse, the last received byte and
// the missing-ACK flag. Commands offered while a sequence runs are dropped.
// The tick channel feeds a two-entry queue; the sequencer steps once per
// queued beat into an output register, so one beat per cycle is sustained
// while the result receiver is ready. An accepted tick beat is held in the
// queue, then registered in the output register, from which its result beat
// is offered. When the result receiver stalls, the output register holds its
// beat and the queue fills up to its two entries before tick.ready drops.
// Reset (rst, synchronous) empties the queue, idles the sequencer with SCL
// and SDA high and sets ack_timeout to 255. Write ack_timeout through
// cfg_wen/cfg_wdata only while no beat is in flight.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic [7:0]      cfg_wdata,
  i2cmbe_tick_if.sink     tick,
  i2cmbe_result_if.source res
);
  import i2cmbe_pkg::*;

  tick_t head;
  logic  head_valid;
  logic  pop;

  i2cmbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  i2cmbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res        (res)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Streams delay ticks into the engine and checks every line beat it returns
// against a pinned result or an in-bench model of the SCL/SDA sequencer. A
// directed table walks the commands, the ACK timeout corners and the ignored
// offers; random I2C transfers with stray commands and random ACK timing
// follow, under several timeout settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbe_pkg::*;

  localparam logic [2:0] KIND_BAD_LO = 3'd6;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;
  localparam int IdleLimit = 4000;

  typedef enum logic [3:0] {
    P_IDLE, P_START, P_STOP, P_ACKBIT, P_TXBIT, P_TXLOW, P_TXREL, P_TXPOLL, P_TXEND, P_RX
  } line_phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] txb;
  } line_cmd_t;

  // One row: an optional timeout write, a command tick, then filler ticks that
  // offer random commands (ignored while busy). The pinned result, if any,
  // applies to the last tick of the row.
  typedef struct {
    bit         set_cfg;
    logic [7:0] cfg_val;
    logic       cv;
    logic [2:0] kind;
    logic [7:0] txb;
    logic       sda_fill;
    int         flip_at;
    int         ticks;
    bit         pinned;
    result_t    last_res;
  } line_case_t;

  line_case_t line_cases [23] = '{
    '{0, 8'd0, 0, KIND_START,  8'h00, 1, 0,   1, 1, '{1, 1, 0, 0, 0, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_BAD_LO, 8'h00, 1, 0,   1, 1, '{1, 1, 0, 0, 0, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_BAD_HI, 8'hFF, 0, 0,   1, 1, '{1, 1, 0, 0, 0, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_START,  8'h00, 1, 0,   3, 1, '{0, 0, 0, 1, 1, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_STOP,   8'h00, 1, 0,   3, 1, '{1, 1, 0, 1, 1, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_ACK,    8'h00, 1, 0,   2, 1, '{0, 0, 0, 1, 1, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_NACK,   8'h00, 0, 0,   2, 1, '{0, 1, 0, 1, 1, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_TX,     8'hFF, 0, 0,  20, 1, '{0, 1, 1, 1, 1, 8'h00, 0}},
    '{0, 8'd0, 1, KIND_TX,     8'h00, 1, 0, 274, 1, '{0, 1, 1, 1, 1, 8'h00, 1}},
    '{0, 8'd0, 1, KIND_RX,     8'h00, 1, 0,  24, 1, '{0, 1, 1, 1, 1, 8'hFF, 1}},
    '{0, 8'd0, 1, KIND_TX,     8'hA5, 0, 0,  20, 0, '0},
    '{1, 8'd1, 1, KIND_TX,     8'h5A, 1, 0,  20, 1, '{0, 1, 1, 1, 1, 8'hFF, 1}},
    '{1, 8'd0, 1, KIND_TX,     8'h00, 1, 0,  20, 1, '{0, 1, 1, 1, 1, 8'hFF, 1}},
    '{1, 8'd2, 1, KIND_TX,     8'h3C, 1, 20, 21, 1, '{0, 1, 1, 1, 1, 8'hFF, 0}},
    '{0, 8'd0, 1, KIND_TX,     8'hC3, 1, 0,  21, 1, '{0, 1, 1, 1, 1, 8'hFF, 1}},
    '{0, 8'd0, 1, KIND_RX,     8'hFF, 0, 0,  24, 1, '{0, 1, 1, 1, 1, 8'h00, 1}},
    '{0, 8'd0, 1, KIND_RX,     8'h00, 1, 2,  24, 0, '0},
    '{0, 8'd0, 0, KIND_STOP,   8'h00, 0, 0,   1, 1, '{0, 1, 0, 0, 0, 8'h7F, 1}},
    '{0, 8'd0, 1, KIND_START,  8'h00, 0, 0,   3, 0, '0},
    '{0, 8'd0, 1, KIND_TX,     8'h01, 0, 0,  20, 0, '0},
    '{0, 8'd0, 1, KIND_NACK,   8'h00, 1, 0,   2, 0, '0},
    '{0, 8'd0, 1, KIND_STOP,   8'h00, 1, 0,   3, 0, '0},
    '{0, 8'd0, 0, KIND_RX,     8'h00, 1, 0,   1, 1, '{1, 1, 0, 0, 0, 8'h7F, 0}}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic [7:0] cfg_wdata;

  i2cmbe_tick_if tick_if ();
  i2cmbe_result_if res_if ();

  i2c_master_byte_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .tick      (tick_if),
    .res       (res_if)
  );

  always #10 clk = ~clk;

  // Model state of the sequencer.
  line_phase_t seq_phase;
  logic [3:0]  seq_bit;
  logic [1:0]  seq_sub;
  logic [7:0]  tx_shift;
  logic [7:0]  polls_left;
  logic [7:0]  rx_hold;
  logic        ack_flag;
  logic        scl_q;
  logic        sda_q;
  logic [7:0]  timeout_reg;

  result_t   pending_levels[$];
  line_cmd_t txn_script[$];
  int        bad_beats;
  int        polls_seen;
  int        ack_poll;
  bit        gaps_on;

  function automatic result_t next_line_levels(input logic cv, input logic [2:0] kind,
                                               input logic [7:0] txb, input logic sda);
    result_t r;
    logic busy, done, rel;
    busy = 1'b0;
    done = 1'b0;
    rel  = 1'b0;
    if (seq_phase == P_IDLE && cv && kind <= KIND_NACK) begin
      seq_sub = '0;
      seq_bit = '0;
      case (kind)
        KIND_START: seq_phase = P_START;
        KIND_STOP:  seq_phase = P_STOP;
        KIND_TX: begin
          seq_phase = P_TXBIT;
          tx_shift = txb;
        end
        KIND_RX: begin
          seq_phase = P_RX;
          tx_shift = '0;
          sda_q = 1'b1;
        end
        KIND_ACK: begin
          seq_phase = P_ACKBIT;
          sda_q = 1'b0;
        end
        default: begin
          seq_phase = P_ACKBIT;
          sda_q = 1'b1;
        end
      endcase
    end
    if (seq_phase != P_IDLE) begin
      busy = 1'b1;
      case (seq_phase)
        P_START: begin
          if (seq_sub == 0) begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            seq_sub = 2'd1;
          end else if (seq_sub == 1) begin
            sda_q = 1'b0;
            seq_sub = 2'd2;
          end else begin
            scl_q = 1'b0;
            done = 1'b1;
          end
        end
        P_STOP: begin
          if (seq_sub == 0) begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            seq_sub = 2'd1;
          end else if (seq_sub == 1) begin
            scl_q = 1'b1;
            seq_sub = 2'd2;
          end else begin
            sda_q = 1'b1;
            done = 1'b1;
          end
        end
        P_ACKBIT: begin
          if (seq_sub == 0) begin
            scl_q = 1'b1;
            seq_sub = 2'd1;
          end else begin
            scl_q = 1'b0;
            done = 1'b1;
          end
        end
        P_TXBIT: begin
          if (seq_sub == 0) begin
            scl_q = 1'b0;
            sda_q = tx_shift[7];
            seq_sub = 2'd1;
          end else begin
            scl_q = 1'b1;
            tx_shift = {tx_shift[6:0], 1'b0};
            seq_sub = 2'd0;
            if (seq_bit >= 7) seq_phase = P_TXLOW;
            else seq_bit = seq_bit + 4'd1;
          end
        end
        P_TXLOW: begin
          scl_q = 1'b0;
          seq_phase = P_TXREL;
        end
        P_TXREL: begin
          rel = 1'b1;
          sda_q = 1'b1;
          scl_q = 1'b1;
          // A zero timeout still gives one poll.
          polls_left = (timeout_reg == 0) ? 8'd1 : timeout_reg;
          seq_phase = P_TXPOLL;
        end
        P_TXPOLL: begin
          rel = 1'b1;
          scl_q = 1'b1;
          polls_left = polls_left - 8'd1;
          if (!sda) begin
            ack_flag = 1'b0;
            seq_phase = P_TXEND;
          end else if (polls_left == 0) begin
            ack_flag = 1'b1;
            seq_phase = P_TXEND;
          end
        end
        P_TXEND: begin
          rel = 1'b1;
          scl_q = 1'b0;
          done = 1'b1;
        end
        default: begin
          rel = 1'b1;
          sda_q = 1'b1;
          if (seq_sub == 0) begin
            scl_q = 1'b1;
            seq_sub = 2'd1;
          end else if (seq_sub == 1) begin
            scl_q = 1'b1;
            tx_shift = {tx_shift[6:0], sda};
            seq_sub = 2'd2;
          end else begin
            scl_q = 1'b0;
            seq_sub = 2'd0;
            if (seq_bit >= 7) begin
              rx_hold = tx_shift;
              done = 1'b1;
            end else begin
              seq_bit = seq_bit + 4'd1;
            end
          end
        end
      endcase
      if (done) begin
        seq_phase = P_IDLE;
        seq_sub = '0;
        seq_bit = '0;
      end
    end
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.sda_released = rel;
    r.busy_res     = busy;
    r.done_res     = done;
    r.rx_byte      = rx_hold;
    r.ack_missing  = ack_flag;
    return r;
  endfunction

  task automatic drive_tick(input logic cv, input logic [2:0] kind, input logic [7:0] txb,
                            input logic sda, input bit pinned, input result_t pin_res);
    result_t predicted;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    tick_if.valid     <= 1'b1;
    tick_if.cmd_valid <= cv;
    tick_if.kind      <= kind;
    tick_if.tx_byte   <= txb;
    tick_if.sda_in    <= sda;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    predicted = next_line_levels(cv, kind, txb, sda);
    pending_levels.push_back(pinned ? pin_res : predicted);
  endtask

  // The timeout is only rewritten once every beat has come back.
  task automatic set_timeout(input logic [7:0] value);
    tick_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    timeout_reg = value;
  endtask

  // Idle ticks mostly start the next command of a planned transfer; the rest
  // are empty ticks, unknown kinds and stray commands. Busy ticks offer noise.
  task automatic run_random_tick();
    logic cv;
    logic [2:0] kind;
    logic [7:0] txb;
    logic sda;
    int pick;
    int n;
    int eff;
    line_cmd_t nxt;
    txb  = 8'($urandom_range(0, 255));
    sda  = 1'($urandom_range(0, 1));
    kind = 3'($urandom_range(0, 7));
    cv   = 1'($urandom_range(0, 1));
    if (seq_phase == P_IDLE) begin
      if (txn_script.size() == 0) begin
        txn_script.push_back('{KIND_START, 8'h00});
        txn_script.push_back('{KIND_TX, 8'($urandom_range(0, 255))});
        n = $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) begin
            txn_script.push_back('{KIND_TX, 8'($urandom_range(0, 255))});
          end else begin
            txn_script.push_back('{KIND_RX, 8'h00});
            txn_script.push_back('{($urandom_range(0, 1) == 0) ? KIND_ACK : KIND_NACK, 8'h00});
          end
        end
        txn_script.push_back('{KIND_STOP, 8'h00});
      end
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        cv = 1'b0;
      end else if (pick == 2) begin
        cv = 1'b1;
        kind = 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
      end else if (pick == 3) begin
        cv = 1'b1;
        kind = 3'($urandom_range(KIND_START, KIND_NACK));
      end else begin
        nxt = txn_script.pop_front();
        cv = 1'b1;
        kind = nxt.kind;
        if (nxt.kind == KIND_TX) txb = nxt.txb;
      end
      if (cv && kind == KIND_TX) begin
        // Choose the poll on which the slave pulls SDA low, or none at all.
        eff = (timeout_reg == 0) ? 1 : timeout_reg;
        polls_seen = 0;
        pick = $urandom_range(0, 4);
        if (pick == 0) ack_poll = 0;
        else if (pick == 1) ack_poll = eff;
        else ack_poll = $urandom_range(1, (eff < 6) ? eff : 6);
      end
    end else if (seq_phase == P_TXPOLL) begin
      polls_seen++;
      sda = (polls_seen == ack_poll) ? 1'b0 : 1'b1;
    end
    drive_tick(cv, kind, txb, sda, 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    bad_beats++;
    if (bad_beats <= 10) begin
      $display("%s: expected scl=%0b sda=%0b rel=%0b busy=%0b done=%0b rx=%02h ack=%0b",
               what, want.scl_level, want.sda_level, want.sda_released, want.busy_res,
               want.done_res, want.rx_byte, want.ack_missing);
      $display("  actual scl=%0b sda=%0b rel=%0b busy=%0b done=%0b rx=%02h ack=%0b",
               got.scl_level, got.sda_level, got.sda_released, got.busy_res,
               got.done_res, got.rx_byte, got.ack_missing);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.scl_level    = res_if.scl_level;
      got.sda_level    = res_if.sda_level;
      got.sda_released = res_if.sda_released;
      got.busy_res     = res_if.busy_res;
      got.done_res     = res_if.done_res;
      got.rx_byte      = res_if.rx_byte;
      got.ack_missing  = res_if.ack_missing;
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected line beat", '0, got);
      end else begin
        want = pending_levels.pop_front();
        if (got !== want) report_mismatch("line beat mismatch", want, got);
      end
    end
  end

  // Result receiver: ready drops for random bursts while gaps are enabled.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && gaps_on && $urandom_range(0, 11) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic sda;
    logic [7:0] tout;
    rst               <= 1'b1;
    cfg_wen           <= 1'b0;
    cfg_wdata         <= '0;
    tick_if.valid     <= 1'b0;
    tick_if.cmd_valid <= 1'b0;
    tick_if.kind      <= KIND_START;
    tick_if.tx_byte   <= '0;
    tick_if.sda_in    <= 1'b1;
    bad_beats   = 0;
    gaps_on     = 1'b1;
    timeout_reg = ACK_TIMEOUT_RESET;
    seq_phase   = P_IDLE;
    seq_bit     = '0;
    seq_sub     = '0;
    tx_shift    = '0;
    polls_left  = '0;
    rx_hold     = '0;
    ack_flag    = 1'b0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    polls_seen  = 0;
    ack_poll    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (line_cases[i]) begin
      if (line_cases[i].set_cfg) set_timeout(line_cases[i].cfg_val);
      for (int t = 1; t <= line_cases[i].ticks; t++) begin
        sda = (t == line_cases[i].flip_at) ? ~line_cases[i].sda_fill : line_cases[i].sda_fill;
        if (t == 1) begin
          drive_tick(line_cases[i].cv, line_cases[i].kind, line_cases[i].txb, sda,
                     line_cases[i].pinned && line_cases[i].ticks == 1, line_cases[i].last_res);
        end else begin
          drive_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), sda,
                     line_cases[i].pinned && t == line_cases[i].ticks, line_cases[i].last_res);
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: tout = 8'd1;
        1: tout = 8'd255;
        3: tout = 8'd2;
        5: tout = 8'd255;
        default: tout = 8'($urandom_range(3, 254));
      endcase
      gaps_on = (p != 5);
      set_timeout(tout);
      repeat (200) run_random_tick();
      while (seq_phase != P_IDLE) run_random_tick();
    end

    tick_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_beats == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/i2cmbe_pkg.sv
design/i2cmbe_if.sv
design/i2cmbe_front.sv
design/i2cmbe_back.sv
design/i2c_master_byte_engine_top.sv
test/tb_top.sv
